// ===== src/csem_pkg.sv =====
package csem_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned STAT_W  = 3;

  localparam logic signed [COUNT_W-1:0] COUNT_TOP   = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_RESET = 16'sh0001;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_WOKE      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_SATURATED = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } q_ctrl_t;

endpackage

// ===== src/csem_req_if.sv =====
interface csem_req_if #(
  parameter int unsigned ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ID_WIDTH-1:0] client_id;

  modport source (output valid, output cmd, output client_id, input ready);
  modport sink   (input valid, input cmd, input client_id, output ready);
endinterface

// ===== src/csem_rsp_if.sv =====
interface csem_rsp_if #(
  parameter int unsigned ID_WIDTH   = 16,
  parameter int unsigned WAIT_WIDTH = 7
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [ID_WIDTH-1:0]   go_client;
  logic [WAIT_WIDTH-1:0] waiters;
  logic signed [15:0]    count_now;

  modport source (output valid, output status, output go_client, output waiters,
                  output count_now, input ready);
  modport sink   (input valid, input status, input go_client, input waiters,
                  input count_now, output ready);
endinterface

// ===== src/csem_ram.sv =====
module csem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/csem_queue.sv =====
module csem_queue import csem_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16,
  localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned FILL_W     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_ctrl_t             ctrl_i,
  input  logic [ID_WIDTH-1:0] push_id_i,
  output logic [FILL_W-1:0]   fill_o,
  output logic [ID_WIDTH-1:0] head_id_o
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctrl_i.flush) begin
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
    end else begin
      if (ctrl_i.push) begin
        tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
      end
      if (ctrl_i.pop) begin
        head_d = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
      end
      fill_d = fill_q + FILL_W'(ctrl_i.push) - FILL_W'(ctrl_i.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // push writes at the tail, pop reads the head; the read data is registered and shows up in the next cycle
  csem_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (tail_q),
    .wdata_i (push_id_i),
    .re_i    (ctrl_i.pop),
    .raddr_i (head_q),
    .rdata_o (head_id_o)
  );

  assign fill_o = fill_q;

endmodule

// ===== src/counting_semaphore_with_wait_queue_unit.sv =====
// the result word is registered from the accepted word; a woken waiter's word waits
// in the read state for the queue read (the wait queue memory has a registered read port)
// throughput: one word per cycle when the result is not stalled; none in the read state
// reset: count is 1, wait queue empty, no result pending; queue memory is not cleared
// writing the count register reloads the count and empties the queue
module counting_semaphore_with_wait_queue_unit import csem_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  csem_req_if.sink         req,
  csem_rsp_if.source       rsp
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  fsm_e state_q, state_d;

  logic signed [COUNT_W-1:0] count_q, count_d;
  logic [FILL_W-1:0]         fill;
  logic [ID_WIDTH-1:0]       head_id;
  q_ctrl_t                   q_ctrl;

  logic    accept;
  logic    taken;
  logic    in_ready;
  logic    do_push;
  logic    do_pop;
  status_e status_d;

  logic                      out_valid_q;
  status_e                   status_q;
  logic [ID_WIDTH-1:0]       go_q;
  logic [FILL_W-1:0]         waiters_q;
  logic signed [COUNT_W-1:0] count_out_q;

  assign taken  = out_valid_q && rsp.ready;
  assign accept = req.valid && in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept && do_pop) state_d = FSM_READ;
      FSM_READ: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    case (state_q)
      FSM_IDLE: in_ready = !out_valid_q || rsp.ready;
      default:  in_ready = 1'b0;
    endcase
  end

  assign req.ready = in_ready;

  // semaphore decision on the current count
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    count_d  = count_q;
    status_d = ST_RELEASED;
    if (req.cmd == CMD_ACQUIRE) begin
      if (count_q > 0) begin
        count_d  = count_q - COUNT_W'(1);
        status_d = ST_GRANTED;
      end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
        status_d = ST_REJECTED;
      end else begin
        do_push  = 1'b1;
        count_d  = count_q - COUNT_W'(1);
        status_d = ST_QUEUED;
      end
    end else begin
      if (count_q < 0 && fill != '0) begin
        do_pop   = 1'b1;
        count_d  = count_q + COUNT_W'(1);
        status_d = ST_WOKE;
      end else if (count_q == COUNT_TOP) begin
        status_d = ST_SATURATED;
      end else begin
        count_d  = count_q + COUNT_W'(1);
        status_d = ST_RELEASED;
      end
    end
  end

  always_comb begin
    q_ctrl.push  = accept && do_push;
    q_ctrl.pop   = accept && do_pop;
    q_ctrl.flush = cfg_we_i;
  end

  csem_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .push_id_i (req.client_id),
    .fill_o    (fill),
    .head_id_o (head_id)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= COUNT_W'(cfg_wdata_i);
      end else if (accept) begin
        count_q <= count_d;
      end
      // a woken waiter's word waits for the queue read
      if (accept) begin
        out_valid_q <= !do_pop;
      end else if (state_q == FSM_READ) begin
        out_valid_q <= 1'b1;
      end else if (taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      go_q        <= (status_d == ST_GRANTED) ? req.client_id : '0;
      waiters_q   <= fill + FILL_W'(do_push) - FILL_W'(do_pop);
      count_out_q <= count_d;
    end else if (state_q == FSM_READ) begin
      go_q <= head_id;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.status    = status_q;
  assign rsp.go_client = go_q;
  assign rsp.waiters   = waiters_q;
  assign rsp.count_now = count_out_q;

endmodule

// ===== tb/counting_semaphore_with_wait_queue_unit_tb.sv =====
module counting_semaphore_with_wait_queue_unit_tb import csem_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH     = 64;
  localparam int unsigned MAX_GAP    = 13;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned RAND_WORDS = 800;

  typedef struct packed {
    status_e            status;
    logic [15:0]        go_client;
    logic [6:0]         waiters;
    logic signed [15:0] count_now;
  } sem_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  csem_req_if req_if ();
  csem_rsp_if rsp_if ();

  counting_semaphore_with_wait_queue_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req        (req_if.sink),
    .rsp        (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // semaphore model
  logic signed [15:0] sem_model;
  logic [15:0]        waiter_ids[$];
  sem_rsp_t           pending_rsp[$];

  int unsigned err_count;
  int unsigned idle_cycles;
  bit          src_gaps;
  bit          sink_gaps;

  function automatic sem_rsp_t semaphore_step(cmd_e cmd, logic [15:0] id);
    sem_rsp_t r;
    r.status    = ST_GRANTED;
    r.go_client = '0;
    if (cmd == CMD_ACQUIRE) begin
      if (sem_model > 16'sd0) begin
        sem_model   = sem_model - 16'sd1;
        r.status    = ST_GRANTED;
        r.go_client = id;
      end else if (waiter_ids.size() >= QDEPTH) begin
        r.status = ST_REJECTED;
      end else begin
        waiter_ids.push_back(id);
        sem_model = sem_model - 16'sd1;
        r.status  = ST_QUEUED;
      end
    end else begin
      if (sem_model < 16'sd0 && waiter_ids.size() > 0) begin
        r.go_client = waiter_ids.pop_front();
        sem_model   = sem_model + 16'sd1;
        r.status    = ST_WOKE;
      end else if (sem_model >= COUNT_TOP) begin
        r.status = ST_SATURATED;
      end else begin
        sem_model = sem_model + 16'sd1;
        r.status  = ST_RELEASED;
      end
    end
    r.waiters   = 7'(waiter_ids.size());
    r.count_now = sem_model;
    return r;
  endfunction

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // called at a rising edge, returns at the edge the word is taken
  task automatic send_word(cmd_e cmd, logic [15:0] id);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.client_id <= id;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(semaphore_step(cmd, id));
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reload_count(logic [CFG_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sem_model = 16'(value);
    waiter_ids.delete();
  endtask

  // response side: random stall per word, then compare with oldest prediction
  initial begin
    sem_rsp_t    want;
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected word status %0d", rsp_if.status));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status)
          report($sformatf("status: expected %0d got %0d", want.status, rsp_if.status));
        if (rsp_if.go_client !== want.go_client)
          report($sformatf("go_client: expected %0d got %0d", want.go_client,
                           rsp_if.go_client));
        if (rsp_if.waiters !== want.waiters)
          report($sformatf("waiters: expected %0d got %0d", want.waiters, rsp_if.waiters));
        if (rsp_if.count_now !== want.count_now)
          report($sformatf("count_now: expected %0d got %0d", want.count_now,
                           rsp_if.count_now));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_reset_count();
    // count comes up at one
    send_word(CMD_ACQUIRE, 16'hFFFF);
    send_word(CMD_ACQUIRE, 16'h0000);
    send_word(CMD_RELEASE, 16'hFFFF);
    send_word(CMD_RELEASE, 16'h0000);
  endtask

  task automatic test_wait_queue_order();
    reload_count(15'd2);
    send_word(CMD_ACQUIRE, 16'h1111);
    send_word(CMD_ACQUIRE, 16'h2222);
    send_word(CMD_ACQUIRE, 16'hAAAA);
    send_word(CMD_ACQUIRE, 16'h5555);
    send_word(CMD_ACQUIRE, 16'h8001);
    repeat (4) send_word(CMD_RELEASE, 16'($urandom));
  endtask

  task automatic test_queue_full();
    reload_count(15'd0);
    repeat (QDEPTH) send_word(CMD_ACQUIRE, 16'($urandom));
    send_word(CMD_ACQUIRE, 16'hFFFF);
    send_word(CMD_ACQUIRE, 16'h0000);
    repeat (QDEPTH + 1) send_word(CMD_RELEASE, 16'($urandom));
  endtask

  task automatic test_count_top();
    reload_count(15'h7FFF);
    send_word(CMD_RELEASE, 16'h0000);
    send_word(CMD_ACQUIRE, 16'h7FFF);
    send_word(CMD_RELEASE, 16'hFFFF);
    send_word(CMD_RELEASE, 16'h1234);
  endtask

  task automatic test_reload_flush();
    reload_count(15'd0);
    send_word(CMD_ACQUIRE, 16'h00FF);
    send_word(CMD_ACQUIRE, 16'hFF00);
    // reload with waiters queued drops them
    reload_count(15'd3);
    send_word(CMD_RELEASE, 16'h0000);
    send_word(CMD_ACQUIRE, 16'hC3C3);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    int unsigned acq_pct;
    int unsigned kind;
    logic [CFG_W-1:0] init;
    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6)       init = CFG_W'($urandom_range(0, 4));
      else if (kind < 8)  init = CFG_W'($urandom_range(0, 32767));
      else if (kind == 8) init = CFG_W'(32767 - $urandom_range(0, 3));
      else                init = '0;
      reload_count(init);
      case ($urandom_range(0, 3))
        0: acq_pct = 30;
        1: acq_pct = 50;
        2: acq_pct = 70;
        default: acq_pct = 90;
      endcase
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      len = $urandom_range(40, 160);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == len / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain_results();
        if ($urandom_range(1, 100) <= acq_pct) send_word(CMD_ACQUIRE, 16'($urandom));
        else send_word(CMD_RELEASE, 16'($urandom));
      end
      sent += len;
      phase++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_ACQUIRE;
    req_if.client_id <= '0;
    err_count = 0;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    sem_model = COUNT_RESET;
    waiter_ids.delete();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_count();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_wait_queue_order();
    test_queue_full();
    src_gaps  = 1'b0;
    test_count_top();
    sink_gaps = 1'b0;
    src_gaps  = 1'b1;
    test_reload_flush();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
